>>> rtl/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define MPBA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

`define MPBA_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`else

`define MPBA_ASSERT(name, prop, msg)

`define MPBA_ASSERT_NEVER(name, cond, msg)

`endif

`endif

>>> rtl/mpba_pkg.sv
`default_nettype none

package mpba_pkg;

  localparam int SIZE_W            = 24;
  localparam int CNT_W             = 6;
  localparam int IDX_W             = 5;
  localparam int POOL_W            = 2;
  localparam int OP_W              = 2;
  localparam int STATUS_W          = 2;
  localparam int CFG_POOLS         = 4;
  localparam int CFG_PIDX_W        = 2;
  localparam int CFG_IDX_W         = 3;
  localparam int POOLS_DEF         = 4;
  localparam int TOTAL_BUFFERS_DEF = 32;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BUFFERS_0 = 3'd4;

  typedef enum logic [OP_W-1:0] {
    OP_GET     = 2'd0,
    OP_FREE    = 2'd1,
    OP_REBUILD = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_POOL    = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_NOT_IN_USE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GET,
    S_FREE,
    S_RESP,
    S_INIT
  } state_e;

endpackage

`default_nettype wire

>>> rtl/mpba_ram.sv
`default_nettype none

module mpba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/multi_pool_buffer_allocator_unit.sv
// Multi-pool buffer allocator.
// Requests enter on in_valid_i/in_stall_o with op_i, request_size_i and
// buffer_index_i; each request gives exactly one response on
// out_valid_o/out_stall_i (status, granted buffer, pool, free count).
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_wdata_i):
// indexes 0-3 set pool sizes, 4-7 the buffers per pool at rebuild.
// Get and free read the link memory entry when the request is taken,
// then write it back and update the pool head in S_GET or S_FREE; the
// response registers in that state, which waits while the output is
// stalled. Requests are handled one at a time: a new one is taken only
// once the previous one has registered its response. Rebuild walks every
// entry of the link memory once, one entry per cycle, with one step per
// pool to move on to the next pool.
// After reset all pools are empty and every buffer reads as not in use;
// no clearing pass is needed. A stalled response waits in the output
// register while the next request is already taken; that request only
// waits if its own response is ready and the output is still stalled.
`default_nettype none

module multi_pool_buffer_allocator_unit #(
  parameter int POOLS         = mpba_pkg::POOLS_DEF,
  parameter int TOTAL_BUFFERS = mpba_pkg::TOTAL_BUFFERS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [mpba_pkg::OP_W-1:0]         op_i,
  input  wire logic [mpba_pkg::SIZE_W-1:0]       request_size_i,
  input  wire logic [mpba_pkg::IDX_W-1:0]        buffer_index_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [mpba_pkg::STATUS_W-1:0]     status_o,
  output logic      [mpba_pkg::IDX_W-1:0]        granted_index_o,
  output logic      [mpba_pkg::POOL_W-1:0]       pool_index_o,
  output logic      [mpba_pkg::CNT_W-1:0]        pool_free_count_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [mpba_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [mpba_pkg::SIZE_W-1:0]       cfg_wdata_i
);

  import mpba_pkg::*;

`include "assert_macros.svh"

  localparam int BW  = $clog2(TOTAL_BUFFERS);
  localparam int CW  = $clog2(TOTAL_BUFFERS + 1);
  localparam int PIW = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int CPW = $clog2(POOLS + 1);
  localparam int EW  = 1 + POOL_W + BW;

  // configuration
  logic [SIZE_W-1:0] pool_size_q [CFG_POOLS];
  logic [CNT_W-1:0]  pool_bufs_q [CFG_POOLS];

  // pool heads
  logic [BW-1:0] top_q [POOLS];
  logic [CW-1:0] cnt_q [POOLS];

  logic [TOTAL_BUFFERS-1:0] ent_vld_q;
  logic                     rd_vld_q;

  state_e state_q, state_d;

  logic [POOL_W-1:0] pool_q;
  logic [BW-1:0]     bidx_q;
  status_e           rsp_status_q;
  logic [CW-1:0]     ini_ptr_q;
  logic [CPW-1:0]    ini_pool_q;

  logic              out_vld_q;
  status_e           out_status_q;
  logic [IDX_W-1:0]  out_granted_q;
  logic [POOL_W-1:0] out_pool_q;
  logic [CNT_W-1:0]  out_cnt_q;

  // memory port
  logic          ram_we, ram_re;
  logic [BW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic              rd_inuse;
  logic [POOL_W-1:0] rd_own;
  logic [BW-1:0]     rd_next;

  logic              in_acc, out_free, in_range;
  logic              get_hit;
  logic [POOL_W-1:0] get_pool;
  logic [CW-1:0]     get_cnt;
  logic [POOL_W-1:0] own_c, free_pool;
  logic [SIZE_W-1:0] free_key;
  logic              ini_done, ini_live, ini_fill;
  logic [POOL_W-1:0] ini_sel;

  logic              out_load;
  status_e           out_status_d;
  logic [IDX_W-1:0]  out_granted_d;
  logic [POOL_W-1:0] out_pool_d;
  logic [CNT_W-1:0]  out_cnt_d;
  logic              hd_we;
  logic [POOL_W-1:0] hd_pool;
  logic [BW-1:0]     hd_top_d;
  logic [CW-1:0]     hd_cnt_d;
  logic              cnt_clr, ptr_inc, pool_inc, vld_set;
  status_e           acc_status;
  int unsigned       cnt_sum;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_vld_q || !out_stall_i;
  assign in_range = int'(buffer_index_i) < TOTAL_BUFFERS;

  assign rd_inuse = ram_rdata[EW-1];
  assign rd_own   = ram_rdata[BW +: POOL_W];
  assign rd_next  = ram_rdata[BW-1:0];

  // first pool matching the requested size, lowest index wins
  always_comb begin
    get_hit  = 1'b0;
    get_pool = '0;
    for (int p = POOLS - 1; p >= 0; p--) begin
      if (pool_size_q[p] == request_size_i) begin
        get_hit  = 1'b1;
        get_pool = POOL_W'(p);
      end
    end
  end

  assign get_cnt = cnt_q[get_pool[PIW-1:0]];

  // free goes back to the first pool with the owner's size
  assign own_c    = (int'(rd_own) >= POOLS) ? '0 : rd_own;
  assign free_key = pool_size_q[own_c];

  always_comb begin
    free_pool = own_c;
    for (int p = POOLS - 1; p >= 0; p--) begin
      if (pool_size_q[p] == free_key) begin
        free_pool = POOL_W'(p);
      end
    end
  end

  assign ini_done = ini_ptr_q == CW'(TOTAL_BUFFERS);
  assign ini_live = int'(ini_pool_q) < POOLS;
  assign ini_sel  = POOL_W'(ini_pool_q);
  assign ini_fill = ini_live &&
                    (int'(cnt_q[ini_sel[PIW-1:0]]) < int'(pool_bufs_q[ini_sel]));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (op_e'(op_i))
            OP_GET:     state_d = (get_hit && get_cnt != '0) ? S_GET : S_RESP;
            OP_FREE:    state_d = in_range ? S_FREE : S_RESP;
            OP_REBUILD: state_d = S_INIT;
            default:    state_d = S_RESP;
          endcase
        end
      end
      S_GET, S_FREE, S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      S_INIT: begin
        if (ini_done && out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    out_load      = 1'b0;
    out_status_d  = ST_OK;
    out_granted_d = '0;
    out_pool_d    = '0;
    out_cnt_d     = '0;
    hd_we         = 1'b0;
    hd_pool       = '0;
    hd_top_d      = '0;
    hd_cnt_d      = '0;
    cnt_clr       = 1'b0;
    ptr_inc       = 1'b0;
    pool_inc      = 1'b0;
    vld_set       = 1'b0;
    acc_status    = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        unique case (op_e'(op_i))
          OP_GET: begin
            acc_status = get_hit ? ST_EMPTY : ST_NO_POOL;
            ram_re     = in_acc && get_hit && get_cnt != '0;
            ram_raddr  = top_q[get_pool[PIW-1:0]];
          end
          OP_FREE: begin
            acc_status = ST_NOT_IN_USE;
            ram_re     = in_acc && in_range;
            ram_raddr  = BW'(buffer_index_i);
          end
          OP_REBUILD: begin
            cnt_clr = in_acc;
          end
          default: acc_status = ST_OK;
        endcase
      end
      S_GET: begin
        if (out_free) begin
          ram_we        = 1'b1;
          ram_waddr     = top_q[pool_q[PIW-1:0]];
          ram_wdata     = {1'b1, rd_own, rd_next};
          hd_we         = 1'b1;
          hd_pool       = pool_q;
          hd_top_d      = rd_next;
          hd_cnt_d      = cnt_q[pool_q[PIW-1:0]] - CW'(1);
          out_load      = 1'b1;
          out_granted_d = IDX_W'(top_q[pool_q[PIW-1:0]]);
          out_pool_d    = pool_q;
          out_cnt_d     = CNT_W'(hd_cnt_d);
        end
      end
      S_FREE: begin
        if (out_free) begin
          out_load = 1'b1;
          if (rd_vld_q && rd_inuse) begin
            ram_we     = 1'b1;
            ram_waddr  = bidx_q;
            ram_wdata  = {1'b0, rd_own, top_q[free_pool[PIW-1:0]]};
            hd_we      = 1'b1;
            hd_pool    = free_pool;
            hd_top_d   = bidx_q;
            hd_cnt_d   = cnt_q[free_pool[PIW-1:0]] + CW'(1);
            out_pool_d = free_pool;
            out_cnt_d  = CNT_W'(hd_cnt_d);
          end else begin
            out_status_d = ST_NOT_IN_USE;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = rsp_status_q;
          out_pool_d   = pool_q;
        end
      end
      S_INIT: begin
        priority if (ini_done) begin
          out_load = out_free;
        end else if (ini_fill) begin
          ram_we    = 1'b1;
          ram_waddr = ini_ptr_q[BW-1:0];
          ram_wdata = {1'b0, ini_sel, top_q[ini_sel[PIW-1:0]]};
          hd_we     = 1'b1;
          hd_pool   = ini_sel;
          hd_top_d  = ini_ptr_q[BW-1:0];
          hd_cnt_d  = cnt_q[ini_sel[PIW-1:0]] + CW'(1);
          vld_set   = 1'b1;
          ptr_inc   = 1'b1;
        end else if (ini_live) begin
          pool_inc = 1'b1;
        end else begin
          // capacity left over: entry just marked not in use
          ram_we    = 1'b1;
          ram_waddr = ini_ptr_q[BW-1:0];
          ram_wdata = '0;
          vld_set   = 1'b1;
          ptr_inc   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ini_ptr_q  <= '0;
      ini_pool_q <= '0;
      ent_vld_q  <= '0;
      out_vld_q  <= 1'b0;
      for (int p = 0; p < CFG_POOLS; p++) begin
        pool_size_q[p] <= '0;
        pool_bufs_q[p] <= '0;
      end
      for (int p = 0; p < POOLS; p++) begin
        cnt_q[p] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i < CFG_POOL_BUFFERS_0) begin
          pool_size_q[CFG_PIDX_W'(cfg_idx_i - CFG_POOL_SIZE_0)] <= cfg_wdata_i;
        end else begin
          pool_bufs_q[CFG_PIDX_W'(cfg_idx_i - CFG_POOL_BUFFERS_0)] <=
            cfg_wdata_i[CNT_W-1:0];
        end
      end
      if (cnt_clr) begin
        ini_ptr_q  <= '0;
        ini_pool_q <= '0;
        for (int p = 0; p < POOLS; p++) begin
          cnt_q[p] <= '0;
        end
      end else begin
        if (hd_we) cnt_q[hd_pool[PIW-1:0]] <= hd_cnt_d;
        if (ptr_inc) ini_ptr_q <= ini_ptr_q + CW'(1);
        if (pool_inc) ini_pool_q <= ini_pool_q + CPW'(1);
      end
      if (vld_set) ent_vld_q[ini_ptr_q[BW-1:0]] <= 1'b1;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hd_we) top_q[hd_pool[PIW-1:0]] <= hd_top_d;
    if (ram_re) rd_vld_q <= ent_vld_q[ram_raddr];
    if (in_acc) begin
      pool_q       <= (op_e'(op_i) == OP_GET && get_hit) ? get_pool : '0;
      bidx_q       <= BW'(buffer_index_i);
      rsp_status_q <= acc_status;
    end
    if (out_load) begin
      out_status_q  <= out_status_d;
      out_granted_q <= out_granted_d;
      out_pool_q    <= out_pool_d;
      out_cnt_q     <= out_cnt_d;
    end
  end

  // reads happen only at request time and writes only afterwards,
  // so the same entry is never read and written in one cycle
  mpba_ram #(
    .WIDTH(EW),
    .DEPTH(TOTAL_BUFFERS)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_stall_o        = state_q != S_IDLE;
  assign out_valid_o       = out_vld_q;
  assign status_o          = out_status_q;
  assign granted_index_o   = out_granted_q;
  assign pool_index_o      = out_pool_q;
  assign pool_free_count_o = out_cnt_q;

  always_comb begin
    cnt_sum = 0;
    for (int p = 0; p < POOLS; p++) begin
      cnt_sum = cnt_sum + int'(cnt_q[p]);
    end
  end

  `MPBA_ASSERT(a_cnt_bound, cnt_sum <= TOTAL_BUFFERS, "free counts exceed buffer total")
  `MPBA_ASSERT(a_acc_busy, in_acc |=> state_q != S_IDLE, "request taken but block idle")
  `MPBA_ASSERT(a_pop_nonempty, state_q == S_GET |-> cnt_q[pool_q[PIW-1:0]] != '0, "pop from empty pool")
  `MPBA_ASSERT_NEVER(a_ptr_range, ini_ptr_q > CW'(TOTAL_BUFFERS), "rebuild pointer out of range")

endmodule

`default_nettype wire

>>> tb/multi_pool_buffer_allocator_unit_tb.sv
`default_nettype none

module multi_pool_buffer_allocator_unit_tb;
  import mpba_pkg::*;

  localparam int NPOOLS      = POOLS_DEF;
  localparam int NBUFS       = TOTAL_BUFFERS_DEF;
  localparam int SETTLE      = NBUFS + NPOOLS + 4;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 12;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

  typedef enum int {STALL_NONE, STALL_SOME, STALL_HEAVY} stall_mode_e;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted;
    logic [POOL_W-1:0]   pool;
    logic [CNT_W-1:0]    count;
  } alloc_result_t;

  // allocator state mirror plus the queue of responses still owed
  class alloc_scoreboard;
    logic [SIZE_W-1:0] size_reg [NPOOLS];
    logic [CNT_W-1:0]  bufs_reg [NPOOLS];
    logic [IDX_W-1:0]  top [NPOOLS];
    int                cnt [NPOOLS];
    logic [IDX_W-1:0]  link [NBUFS];
    bit                used [NBUFS];
    int                owner [NBUFS];
    alloc_result_t     owed_q [$];
    int errors;
    int checked;
    int status_seen [4];
    int rebuilds;

    function new();
      foreach (size_reg[p]) begin
        size_reg[p] = '0;
        bufs_reg[p] = '0;
        top[p] = '0;
        cnt[p] = 0;
      end
      foreach (used[b]) begin
        used[b] = 1'b0;
        link[b] = '0;
        owner[b] = 0;
      end
      errors = 0;
      checked = 0;
      rebuilds = 0;
      foreach (status_seen[s]) status_seen[s] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
      if (idx < CFG_POOL_BUFFERS_0) size_reg[idx - CFG_POOL_SIZE_0] = data;
      else bufs_reg[idx - CFG_POOL_BUFFERS_0] = data[CNT_W-1:0];
    endfunction

    function int match_pool(logic [SIZE_W-1:0] size);
      for (int p = 0; p < NPOOLS; p++)
        if (size_reg[p] == size) return p;
      return -1;
    endfunction

    function void push_free(int p, int b);
      link[b] = top[p];
      top[p] = IDX_W'(b);
      cnt[p]++;
    endfunction

    function void rebuild_pools();
      int slot;
      slot = 0;
      foreach (used[b]) used[b] = 1'b0;
      for (int p = 0; p < NPOOLS; p++) begin
        cnt[p] = 0;
        top[p] = '0;
      end
      for (int p = 0; p < NPOOLS; p++)
        for (int i = 0; i < int'(bufs_reg[p]) && slot < NBUFS; i++) begin
          owner[slot] = p;
          push_free(p, slot);
          slot++;
        end
    endfunction

    function int pick_in_use();
      int list [$];
      foreach (used[b]) if (used[b]) list.push_back(b);
      if (list.size() == 0) return -1;
      return list[$urandom_range(0, list.size() - 1)];
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size,
                               logic [IDX_W-1:0] bidx);
      alloc_result_t r;
      int p;
      int b;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_GET: begin
          p = match_pool(size);
          if (p < 0) begin
            r.status = ST_NO_POOL;
          end else if (cnt[p] == 0) begin
            r.status = ST_EMPTY;
            r.pool = POOL_W'(p);
          end else begin
            b = top[p];
            top[p] = link[b];
            cnt[p]--;
            used[b] = 1'b1;
            r.granted = IDX_W'(b);
            r.pool = POOL_W'(p);
            r.count = CNT_W'(cnt[p]);
          end
        end
        OP_FREE: begin
          if (!used[bidx]) begin
            r.status = ST_NOT_IN_USE;
          end else begin
            // goes back to the first pool of the owner's current size
            p = match_pool(size_reg[owner[bidx]]);
            if (p < 0) p = owner[bidx];
            used[bidx] = 1'b0;
            push_free(p, bidx);
            r.pool = POOL_W'(p);
            r.count = CNT_W'(cnt[p]);
          end
        end
        OP_REBUILD: begin
          rebuild_pools();
          rebuilds++;
        end
        default: ;
      endcase
      status_seen[r.status]++;
      owed_q.push_back(r);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void field_check(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (got !== want)
        note_error($sformatf("response %0d %s expected %0d got %0d", checked, name, want, got));
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (owed_q.size() == 0) begin
        note_error($sformatf("response with no outstanding request: %p", got));
        return;
      end
      want = owed_q.pop_front();
      field_check("status", CNT_W'(want.status), CNT_W'(got.status));
      field_check("granted_index", CNT_W'(want.granted), CNT_W'(got.granted));
      field_check("pool_index", CNT_W'(want.pool), CNT_W'(got.pool));
      field_check("pool_free_count", want.count, got.count);
      checked++;
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [OP_W-1:0]       op_i;
  logic [SIZE_W-1:0]     request_size_i;
  logic [IDX_W-1:0]      buffer_index_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [STATUS_W-1:0]   status_o;
  logic [IDX_W-1:0]      granted_index_o;
  logic [POOL_W-1:0]     pool_index_o;
  logic [CNT_W-1:0]      pool_free_count_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [SIZE_W-1:0]     cfg_wdata_i;

  alloc_scoreboard sb = new();
  bit hold_req = 1'b0;
  int holds_done = 0;
  int burst_left = 0;

  multi_pool_buffer_allocator_unit #(
    .POOLS        (NPOOLS),
    .TOTAL_BUFFERS(NBUFS)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .request_size_i   (request_size_i),
    .buffer_index_i   (buffer_index_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .granted_index_o  (granted_index_o),
    .pool_index_o     (pool_index_o),
    .pool_free_count_o(pool_free_count_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({status_o, granted_index_o, pool_index_o, pool_free_count_o});
  end

  // response side back-pressure
  initial begin
    stall_mode_e mode;
    int mode_left;
    mode = STALL_NONE;
    mode_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          STALL_NONE: out_stall_i <= 1'b0;
          STALL_SOME: out_stall_i <= 1'($urandom_range(0, 1));
          default:    out_stall_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_request(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size,
                              logic [IDX_W-1:0] bidx);
    in_valid_i <= 1'b1;
    op_i <= op;
    request_size_i <= size;
    buffer_index_i <= bidx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(op, size, bidx);
  endtask

  // bursts of back-to-back requests separated by random gaps
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
  endtask

  task automatic request(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size,
                         logic [IDX_W-1:0] bidx);
    send_request(op, size, bidx);
    pace();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(logic [SIZE_W-1:0] sizes [NPOOLS], int bufs [NPOOLS]);
    for (int p = 0; p < NPOOLS; p++) begin
      write_reg(CFG_POOL_SIZE_0 + CFG_IDX_W'(p), sizes[p]);
      write_reg(CFG_POOL_BUFFERS_0 + CFG_IDX_W'(p), SIZE_W'(bufs[p]));
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic phase_config(int ph);
    logic [SIZE_W-1:0] sizes [NPOOLS];
    int bufs [NPOOLS];
    case (ph)
      0: begin
        // every pool the same size, counts over capacity
        sizes = '{default: '0};
        bufs = '{default: 32};
      end
      1: begin
        sizes = '{SIZE_MAX, 1, 2, 3};
        bufs = '{default: 0};
      end
      2: begin
        sizes = '{16, 32, 48, 64};
        bufs = '{default: 8};
      end
      3: begin
        sizes = '{5, 9, 5, 9};
        bufs = '{2, 1, 20, 9};
      end
      default: begin
        sizes = '{default: '0};
        for (int p = 0; p < NPOOLS; p++) begin
          case ($urandom_range(0, 3))
            0:       sizes[p] = SIZE_W'($urandom());
            1:       sizes[p] = sizes[$urandom_range(0, NPOOLS - 1)];
            default: sizes[p] = SIZE_W'($urandom_range(0, 15));
          endcase
          bufs[p] = $urandom_range(0, 32);
        end
      end
    endcase
    configure(sizes, bufs);
  endtask

  task automatic random_request();
    int r;
    int b;
    logic [SIZE_W-1:0] junk_size;
    logic [IDX_W-1:0] junk_idx;
    r = $urandom_range(0, 99);
    junk_size = SIZE_W'($urandom());
    junk_idx = IDX_W'($urandom());
    b = sb.pick_in_use();
    if (r < 45 || (r < 80 && b < 0))
      request(OP_GET, sb.size_reg[$urandom_range(0, NPOOLS - 1)], junk_idx);
    else if (r < 80)
      request(OP_FREE, junk_size, IDX_W'(b));
    else if (r < 86)
      request(OP_FREE, junk_size, junk_idx);
    else if (r < 92)
      request(OP_GET, junk_size, junk_idx);
    else if (r < 95)
      request(OP_REBUILD, junk_size, junk_idx);
    else
      request(OP_UNUSED, junk_size, junk_idx);
  endtask

  initial begin
    logic [SIZE_W-1:0] sizes [NPOOLS];
    int bufs [NPOOLS];
    int n;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    op_i <= OP_GET;
    request_size_i <= '0;
    buffer_index_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_POOL_SIZE_0;
    cfg_wdata_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers still at reset: size 0 matches pool 0, which is empty
    request(OP_GET, '0, '0);
    request(OP_GET, SIZE_MAX, '1);
    request(OP_FREE, '0, '0);
    request(OP_FREE, SIZE_MAX, '1);
    request(OP_UNUSED, SIZE_MAX, '1);
    request(OP_REBUILD, '0, '0);
    drain();

    // pool 3 asks for more than is left, so it gets cut
    sizes = '{64, SIZE_MAX, 32, 1};
    bufs = '{3, 5, 4, 32};
    configure(sizes, bufs);
    request(OP_REBUILD, '0, '0);
    repeat (3) request(OP_GET, 64, '0);
    request(OP_GET, 64, '0);
    request(OP_FREE, '0, 5'd1);
    request(OP_FREE, '0, 5'd1);
    request(OP_GET, SIZE_MAX, '0);
    request(OP_GET, 32, '0);
    request(OP_GET, '0, '0);
    request(OP_GET, 1, '0);
    request(OP_FREE, '0, 5'd30);
    request(OP_UNUSED, SIZE_MAX, '1);
    drain();
    // pool 2 now shares its size with pool 0, so its buffer returns to pool 0
    write_reg(CFG_POOL_SIZE_0 + CFG_IDX_W'(2), 64);
    cfg_we_i <= 1'b0;
    request(OP_FREE, '0, 5'd11);
    request(OP_REBUILD, '0, '0);
    request(OP_FREE, '0, 5'd31);
    request(OP_GET, 64, '0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      phase_config(ph);
      if (ph < 4 || $urandom_range(0, 3) != 0)
        request(OP_REBUILD, SIZE_W'($urandom()), IDX_W'($urandom()));
      if (ph == 2 || ph == 7) hold_req = 1'b1;
      n = $urandom_range(90, 120);
      repeat (n) random_request();
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    while (sb.pending() != 0) begin
      sb.note_error($sformatf("request left without response: %p", sb.owed_q.pop_front()));
    end

    $display("checked %0d responses over %0d rebuilds and %0d long output holds",
             sb.checked, sb.rebuilds, holds_done);
    $display("grants/returns ok %0d, no pool %0d, empty pool %0d, not in use %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_NO_POOL],
             sb.status_seen[ST_EMPTY], sb.status_seen[ST_NOT_IN_USE]);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> multi_pool_buffer_allocator_unit.f
+incdir+rtl
rtl/mpba_pkg.sv
rtl/mpba_ram.sv
rtl/multi_pool_buffer_allocator_unit.sv
tb/multi_pool_buffer_allocator_unit_tb.sv
